// ===== rtl/plom_pkg.sv =====
package plom_pkg;

    localparam int PRICE_TICKS = 1024;
    localparam int TICK_BITS = $clog2(PRICE_TICKS);
    localparam int MAX_MATCH_LEVELS = 32;
    localparam int LEVEL_BITS = $clog2(MAX_MATCH_LEVELS + 1);
    localparam int QTY_BITS = 24;
    localparam logic [QTY_BITS-1:0] QTY_MAX = {QTY_BITS{1'b1}};

    typedef struct packed {
        logic        order_side;
        logic        order_kind;
        logic [9:0]  limit_tick;
        logic [23:0] order_qty;
        logic [31:0] order_ident;
    } order_t;

    typedef struct packed {
        logic        is_trade;
        logic [31:0] buyer_ident;
        logic [31:0] seller_ident;
        logic [9:0]  trade_tick;
        logic [23:0] trade_qty;
        logic [23:0] left_qty;
        logic        rested;
        logic [31:0] trades_so_far;
        logic [63:0] volume_so_far;
        logic        last;
    } result_t;

    typedef struct packed {
        logic                rd_en;
        logic                wr_en;
        logic                side;
        logic [TICK_BITS-1:0] addr;
        logic [QTY_BITS-1:0]  wdata;
    } book_req_t;

endpackage

// ===== rtl/plom_book.sv =====
module plom_book (
    input  logic                 clk,
    input  plom_pkg::book_req_t  req,
    output logic [plom_pkg::QTY_BITS-1:0] rdata
);
    import plom_pkg::*;

    logic [QTY_BITS-1:0] bid_mem [PRICE_TICKS];
    logic [QTY_BITS-1:0] ask_mem [PRICE_TICKS];
    logic [QTY_BITS-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en && !req.side)
        begin
            bid_mem[req.addr] <= req.wdata;
        end
        if (req.wr_en && req.side)
        begin
            ask_mem[req.addr] <= req.wdata;
        end
        if (req.rd_en)
        begin
            rdata_reg <= req.side ? ask_mem[req.addr] : bid_mem[req.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/price_level_order_matcher.sv =====
// Order matcher over a per-tick book of 1024 bid and 1024 ask levels held in
// two single-port memories. After reset the block sweeps both memories to
// zero, one entry per cycle, before it takes the first order. An order then
// walks the opposite side one tick at a time: each tick is a registered read,
// then compare and write back through the one shared subtract/min unit. Last
// the block rests the remainder and delivers the final item. The scan always
// starts at the edge of the book (tick 0 for a buy, tick 1023 for a sell), not
// at the best level, so the cost follows the ticks scanned, and a walk over a
// whole empty side reads every tick of it.
// One order is in work at a time; in_stall stays high until its final item
// is taken. Results come out as trade items then one final item with last=1.
module price_level_order_matcher (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  plom_pkg::order_t   in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output plom_pkg::result_t  out_data
);
    import plom_pkg::*;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_EVAL  = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;
    localparam logic [2:0] ST_RREST = 3'd5;
    localparam logic [2:0] ST_WREST = 3'd6;
    localparam logic [2:0] ST_FINAL = 3'd7;

    logic [2:0]            state_reg, state_next;
    logic [TICK_BITS:0]    cnt_reg, cnt_next;
    logic [LEVEL_BITS-1:0] levels_reg, levels_next;
    order_t                ord_reg, ord_next;
    logic [QTY_BITS-1:0]   remain_reg, remain_next;
    logic [31:0]           trades_reg, trades_next;
    logic [63:0]           volume_reg, volume_next;
    result_t               out_reg, out_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  rested_reg, rested_next;
    book_req_t             req;
    logic [QTY_BITS-1:0]   rdata;
    logic [TICK_BITS-1:0]  tick;
    logic [QTY_BITS-1:0]   fill;
    logic [QTY_BITS:0]     rsum;
    logic                  crossed;

    plom_book u_book (.clk(clk), .req(req), .rdata(rdata));

    assign tick = ord_reg.order_side ? TICK_BITS'(PRICE_TICKS - 1) - cnt_reg[TICK_BITS-1:0]
                                     : cnt_reg[TICK_BITS-1:0];
    assign fill = (remain_reg < rdata) ? remain_reg : rdata;
    assign rsum = {1'b0, rdata} + {1'b0, remain_reg};
    assign crossed = !ord_reg.order_kind &&
                     (ord_reg.order_side ? (tick < ord_reg.limit_tick)
                                         : (tick > ord_reg.limit_tick));

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        levels_next    = levels_reg;
        ord_next       = ord_reg;
        remain_next    = remain_reg;
        trades_next    = trades_reg;
        volume_next    = volume_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && out_stall;
        rested_next    = rested_reg;
        req            = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                req.wr_en = 1'b1;
                req.addr  = cnt_reg[TICK_BITS-1:0];
                req.side  = 1'b0;
                if (cnt_reg[TICK_BITS])
                begin
                    req.side  = 1'b1;
                    req.addr  = ~cnt_reg[TICK_BITS-1:0];
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == {(TICK_BITS+1){1'b1}})
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    ord_next    = in_data;
                    remain_next = in_data.order_qty;
                    cnt_next    = '0;
                    levels_next = '0;
                    rested_next = 1'b0;
                    state_next  = ST_READ;
                end
            end
            ST_READ:
            begin
                if (remain_reg == '0 || levels_reg == LEVEL_BITS'(MAX_MATCH_LEVELS) ||
                    cnt_reg[TICK_BITS])
                begin
                    state_next = ST_RREST;
                end
                else
                begin
                    req.rd_en  = 1'b1;
                    req.side   = !ord_reg.order_side;
                    req.addr   = tick;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (rdata == '0)
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = ST_READ;
                end
                else if (crossed)
                begin
                    state_next = ST_RREST;
                end
                else if (!out_valid_reg || !out_stall)
                begin
                    req.wr_en   = 1'b1;
                    req.side    = !ord_reg.order_side;
                    req.addr    = tick;
                    req.wdata   = rdata - fill;
                    remain_next = remain_reg - fill;
                    levels_next = levels_reg + 1'b1;
                    trades_next = trades_reg + 32'd1;
                    volume_next = volume_reg + 64'(fill);
                    out_next.is_trade      = 1'b1;
                    out_next.buyer_ident   = ord_reg.order_side ? 32'd0 : ord_reg.order_ident;
                    out_next.seller_ident  = ord_reg.order_side ? ord_reg.order_ident : 32'd0;
                    out_next.trade_tick    = tick;
                    out_next.trade_qty     = fill;
                    out_next.left_qty      = remain_reg - fill;
                    out_next.rested        = 1'b0;
                    out_next.trades_so_far = trades_reg + 32'd1;
                    out_next.volume_so_far = volume_reg + 64'(fill);
                    out_next.last          = 1'b0;
                    out_valid_next         = 1'b1;
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_RREST:
            begin
                if (remain_reg != '0 && !ord_reg.order_kind)
                begin
                    req.rd_en  = 1'b1;
                    req.side   = ord_reg.order_side;
                    req.addr   = ord_reg.limit_tick;
                    state_next = ST_WREST;
                end
                else
                begin
                    state_next = ST_FINAL;
                end
            end
            ST_WREST:
            begin
                req.wr_en   = 1'b1;
                req.side    = ord_reg.order_side;
                req.addr    = ord_reg.limit_tick;
                req.wdata   = rsum[QTY_BITS] ? QTY_MAX : rsum[QTY_BITS-1:0];
                rested_next = 1'b1;
                state_next  = ST_FINAL;
            end
            ST_FINAL:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_next.is_trade      = 1'b0;
                    out_next.buyer_ident   = ord_reg.order_side ? 32'd0 : ord_reg.order_ident;
                    out_next.seller_ident  = ord_reg.order_side ? ord_reg.order_ident : 32'd0;
                    out_next.trade_tick    = ord_reg.limit_tick;
                    out_next.trade_qty     = '0;
                    out_next.left_qty      = remain_reg;
                    out_next.rested        = rested_reg;
                    out_next.trades_so_far = trades_reg;
                    out_next.volume_so_far = volume_reg;
                    out_next.last          = 1'b1;
                    out_valid_next         = 1'b1;
                    state_next             = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cnt_reg       <= '0;
            levels_reg    <= '0;
            trades_reg    <= '0;
            volume_reg    <= '0;
            out_valid_reg <= 1'b0;
            rested_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            levels_reg    <= levels_next;
            trades_reg    <= trades_next;
            volume_reg    <= volume_next;
            out_valid_reg <= out_valid_next;
            rested_reg    <= rested_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ord_reg    <= ord_next;
        remain_reg <= remain_next;
        out_reg    <= out_next;
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == ST_READ))
        else $error("accepted order did not start walk");
    assert property (@(posedge clk) disable iff (!rst_n)
        (levels_reg <= LEVEL_BITS'(MAX_MATCH_LEVELS)))
        else $error("level count overrun");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> $stable(out_data))
        else $error("stalled result changed");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EVAL) |-> $past(state_reg == ST_READ || state_reg == ST_EVAL))
        else $error("evaluate without read");

endmodule

// ===== tb/plom_checker.sv =====
module plom_checker
    import plom_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  logic    in_stall,
    input  order_t  in_data,
    input  logic    out_valid,
    input  logic    out_stall,
    input  result_t out_data,
    output int      fail_count,
    output int      pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int EXP_DEPTH = 64;

    logic [QTY_BITS-1:0] bid_book [PRICE_TICKS];
    logic [QTY_BITS-1:0] ask_book [PRICE_TICKS];
    logic [31:0] trade_total;
    logic [63:0] volume_total;
    result_t exp_buf [EXP_DEPTH];
    int wr_count;
    int rd_count;

    assign pending = wr_count - rd_count;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
        fail_count++;
    endtask

    task automatic put_expected(input result_t r);
        exp_buf[wr_count % EXP_DEPTH] = r;
        wr_count++;
    endtask

    task automatic match_order(input order_t ord);
        logic [QTY_BITS-1:0] remain;
        logic [QTY_BITS-1:0] avail;
        logic [QTY_BITS-1:0] fill;
        logic [QTY_BITS:0] sum;
        int levels;
        int t;
        logic rest;
        result_t r;
        remain = ord.order_qty;
        levels = 0;
        rest = 1'b0;
        for (int k = 0; k < PRICE_TICKS; k++)
        begin
            t = ord.order_side ? PRICE_TICKS - 1 - k : k;
            if (remain == 0 || levels >= MAX_MATCH_LEVELS)
                break;
            avail = ord.order_side ? bid_book[t] : ask_book[t];
            if (avail == 0)
                continue;
            if (!ord.order_kind &&
                (ord.order_side ? (t < ord.limit_tick) : (t > ord.limit_tick)))
                break;
            fill = remain < avail ? remain : avail;
            if (ord.order_side)
                bid_book[t] = avail - fill;
            else
                ask_book[t] = avail - fill;
            remain = remain - fill;
            levels++;
            trade_total = trade_total + 32'd1;
            volume_total = volume_total + 64'(fill);
            r = '0;
            r.is_trade = 1'b1;
            r.buyer_ident = ord.order_side ? 32'd0 : ord.order_ident;
            r.seller_ident = ord.order_side ? ord.order_ident : 32'd0;
            r.trade_tick = t[9:0];
            r.trade_qty = fill;
            r.left_qty = remain;
            r.trades_so_far = trade_total;
            r.volume_so_far = volume_total;
            put_expected(r);
        end
        if (remain != 0 && !ord.order_kind)
        begin
            if (ord.order_side)
            begin
                sum = {1'b0, ask_book[ord.limit_tick]} + {1'b0, remain};
                ask_book[ord.limit_tick] = sum[QTY_BITS] ? QTY_MAX : sum[QTY_BITS-1:0];
            end
            else
            begin
                sum = {1'b0, bid_book[ord.limit_tick]} + {1'b0, remain};
                bid_book[ord.limit_tick] = sum[QTY_BITS] ? QTY_MAX : sum[QTY_BITS-1:0];
            end
            rest = 1'b1;
        end
        r = '0;
        r.buyer_ident = ord.order_side ? 32'd0 : ord.order_ident;
        r.seller_ident = ord.order_side ? ord.order_ident : 32'd0;
        r.trade_tick = ord.limit_tick;
        r.left_qty = remain;
        r.rested = rest;
        r.trades_so_far = trade_total;
        r.volume_so_far = volume_total;
        r.last = 1'b1;
        put_expected(r);
    endtask

    task automatic compare_result(input result_t got);
        result_t w;
        if (rd_count == wr_count)
        begin
            report_mismatch("unexpected item", 64'(got.trade_qty), '0);
            return;
        end
        w = exp_buf[rd_count % EXP_DEPTH];
        rd_count++;
        if (got.is_trade !== w.is_trade)
            report_mismatch("is_trade", 64'(got.is_trade), 64'(w.is_trade));
        if (got.buyer_ident !== w.buyer_ident)
            report_mismatch("buyer_ident", 64'(got.buyer_ident), 64'(w.buyer_ident));
        if (got.seller_ident !== w.seller_ident)
            report_mismatch("seller_ident", 64'(got.seller_ident), 64'(w.seller_ident));
        if (got.trade_tick !== w.trade_tick)
            report_mismatch("trade_tick", 64'(got.trade_tick), 64'(w.trade_tick));
        if (got.trade_qty !== w.trade_qty)
            report_mismatch("trade_qty", 64'(got.trade_qty), 64'(w.trade_qty));
        if (got.left_qty !== w.left_qty)
            report_mismatch("left_qty", 64'(got.left_qty), 64'(w.left_qty));
        if (got.rested !== w.rested)
            report_mismatch("rested", 64'(got.rested), 64'(w.rested));
        if (got.trades_so_far !== w.trades_so_far)
            report_mismatch("trades_so_far", 64'(got.trades_so_far), 64'(w.trades_so_far));
        if (got.volume_so_far !== w.volume_so_far)
            report_mismatch("volume_so_far", got.volume_so_far, w.volume_so_far);
        if (got.last !== w.last)
            report_mismatch("last", 64'(got.last), 64'(w.last));
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            fail_count = 0;
            wr_count = 0;
            rd_count = 0;
            trade_total = '0;
            volume_total = '0;
            for (int i = 0; i < PRICE_TICKS; i++)
            begin
                bid_book[i] = '0;
                ask_book[i] = '0;
            end
        end
        else
        begin
            if (out_valid && !out_stall)
                compare_result(out_data);
            if (in_valid && !in_stall)
                match_order(in_data);
        end
    end
endmodule

// ===== tb/tb_top.sv =====
module tb_top;
    import plom_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    order_t in_data;
    logic out_valid;
    logic out_stall;
    result_t out_data;
    int fail_count;
    int pending;
    int quiet_cycles;
    int stall_len;
    bit hold_req;
    bit hold_done;
    bit driving_done;

    localparam int QUIET_LIMIT = 20000;

    price_level_order_matcher u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );

    plom_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .fail_count(fail_count), .pending(pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    task automatic send_order(input logic side, input logic kind, input logic [9:0] tick,
                              input logic [23:0] qty, input logic [31:0] ident);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
        repeat (gap) @(negedge clk);
        in_data = '{side, kind, tick, qty, ident};
        in_valid = 1'b1;
        while (in_stall) @(negedge clk);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic random_order(input int mode);
        logic [9:0] tick;
        logic [23:0] qty;
        tick = 10'd500 + 10'($urandom_range(0, 40)) - 10'd20;
        qty = ($urandom_range(0, 9) == 0) ? 24'($urandom) : 24'($urandom_range(1, 5000));
        if (mode == 1)
            tick = 10'($urandom);
        if ($urandom_range(0, 19) == 0)
            qty = 24'd0;
        send_order(1'($urandom_range(0, 1)), $urandom_range(0, 5) == 0, tick, qty, $urandom);
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        hold_req = 1'b0;
        driving_done = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        send_order(1'b0, 1'b0, 10'd0, 24'hFFFFFF, 32'hFFFFFFFF);
        send_order(1'b0, 1'b0, 10'd0, 24'h000005, 32'h00000001);
        send_order(1'b1, 1'b1, 10'd0, 24'h000003, 32'h80000000);
        send_order(1'b1, 1'b0, 10'd1023, 24'h000010, 32'h12345678);
        send_order(1'b1, 1'b0, 10'd1023, 24'hFFFFFF, 32'h0);
        send_order(1'b0, 1'b1, 10'd0, 24'h000008, 32'hA5A5A5A5);
        send_order(1'b0, 1'b0, 10'd5, 24'd0, 32'h5A5A5A5A);
        send_order(1'b1, 1'b1, 10'd0, 24'hFFFFFF, 32'h3);
        for (int i = 0; i < 40; i++)
            send_order(1'b1, 1'b0, 10'(100 + i), 24'd7, 32'(i + 100));
        send_order(1'b0, 1'b0, 10'd200, 24'hFFFFFF, 32'hCAFE0001);
        send_order(1'b0, 1'b1, 10'd0, 24'hFFFFFF, 32'hCAFE0002);
        send_order(1'b1, 1'b1, 10'd0, 24'hFFFFFF, 32'hCAFE0003);
        send_order(1'b1, 1'b0, 10'd1023, 24'h1, 32'h7);
        while (pending != 0) @(negedge clk);
        for (int i = 0; i < 110; i++)
        begin
            if (i == 40)
                hold_req = 1'b1;
            random_order(i % 7 == 0);
            if (i == 90)
                while (pending != 0) @(negedge clk);
        end
        driving_done = 1'b1;
    end

    initial
    begin
        hold_done = 1'b0;
        out_stall = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                out_stall = 1'b1;
                repeat (300) @(negedge clk);
                hold_done = 1'b1;
            end
            stall_len = $urandom_range(0, 16);
            if (stall_len == 0 || $urandom_range(0, 1) == 0)
                out_stall = 1'b0;
            else
            begin
                out_stall = 1'b1;
                repeat (stall_len) @(negedge clk);
                out_stall = 1'b0;
            end
            while (!out_valid) @(negedge clk);
        end
    end

    initial
    begin
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        wait (driving_done);
        while (pending != 0) @(posedge clk);
        repeat (3000) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

// ===== price_level_order_matcher.f =====
rtl/plom_pkg.sv
rtl/plom_book.sv
rtl/price_level_order_matcher.sv
tb/plom_checker.sv
tb/tb_top.sv
